>>> sv/srdp_pkg.sv
// ----------------------------------------------------------------------------
// srdp_pkg
// Types, constants and the channel-to-group map for the sensor ring
// direction percent unit.
// ----------------------------------------------------------------------------
`default_nettype none

package srdp_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int SUM_BITS_DEF    = 20;
	localparam int CHAN_W          = 5;
	localparam int SAMPLE_W        = SAMPLE_BITS_DEF;
	localparam int PCT_W           = 7;
	localparam int NUM_GROUPS      = 4;
	localparam int GRP_IDX_W       = 2;
	localparam int STEP_W          = 3;
	localparam int PCT_SCALE       = 100;

	typedef enum logic [2:0] {
		GRP_LEFT  = 3'd0,
		GRP_RIGHT = 3'd1,
		GRP_FRONT = 3'd2,
		GRP_BACK  = 3'd3,
		GRP_NONE  = 3'd4
	} grp_t;

	typedef struct packed {
		logic [CHAN_W-1:0]   chan;
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} item_t;

	typedef struct packed {
		logic [PCT_W-1:0] left_pct;
		logic [PCT_W-1:0] right_pct;
		logic [PCT_W-1:0] front_pct;
		logic [PCT_W-1:0] back_pct;
		logic             zero_total;
	} result_t;

	// fixed channel map of the ring, channel 31 belongs to no group
	function automatic grp_t group_of(input logic [CHAN_W-1:0] chan);
		grp_t g;
		unique case (chan) inside
			[5'd0:5'd4], [5'd26:5'd30]:                  g = GRP_BACK;
			[5'd5:5'd9], 5'd11, 5'd13:                   g = GRP_LEFT;
			5'd10, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20:    g = GRP_FRONT;
			5'd15, 5'd17, 5'd19, [5'd21:5'd25]:          g = GRP_RIGHT;
			default:                                     g = GRP_NONE;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

>>> sv/srdp_accum.sv
// ----------------------------------------------------------------------------
// srdp_accum
// Four saturating group sums, one sample added per accepted transaction on a mapped channel.
// ----------------------------------------------------------------------------
`default_nettype none

module srdp_accum
	import srdp_pkg::*;
#(
	parameter int SUM_BITS = SUM_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 add_en,
	input  wire logic [CHAN_W-1:0]                    chan,
	input  wire logic [SAMPLE_W-1:0]                  sample,
	input  wire logic                                 clear,
	output logic      [NUM_GROUPS-1:0][SUM_BITS-1:0]  sums
);

	localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

	grp_t                             grp;
	logic [SUM_BITS:0]                add_sum;
	logic [SUM_BITS-1:0]              sat_sum;
	logic [GRP_IDX_W-1:0]             grp_idx;
	logic [NUM_GROUPS-1:0][SUM_BITS-1:0] sums_q;

	assign grp     = group_of(chan);
	assign grp_idx = grp[GRP_IDX_W-1:0];
	assign add_sum = {1'b0, sums_q[grp_idx]} + (SUM_BITS+1)'(sample);
	assign sat_sum = add_sum[SUM_BITS] ? SUM_MAX : add_sum[SUM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (clear) begin
			sums_q <= '0;
		end else if (add_en && grp != GRP_NONE) begin
			sums_q[grp_idx] <= sat_sum;
		end
	end

	assign sums = sums_q;

endmodule

`default_nettype wire

>>> sv/srdp_div.sv
// ----------------------------------------------------------------------------
// srdp_div
// Shared restoring divider: (200 * part + total) / (2 * total), one quotient
// bit per cycle, seven quotient bits per start.
// ----------------------------------------------------------------------------
`default_nettype none

module srdp_div
	import srdp_pkg::*;
#(
	parameter int SUM_BITS = SUM_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [SUM_BITS-1:0]   part,
	input  wire logic [SUM_BITS+1:0]   total,
	output logic                       done,
	output logic      [PCT_W-1:0]      quot
);

	localparam int NUM_W = SUM_BITS + 9;

	logic [NUM_W-1:0]  part_x;
	logic [NUM_W-1:0]  num_init;
	logic [NUM_W-1:0]  den_init;
	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  den_q;
	logic [PCT_W-1:0]  quot_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	// 200 * part as shift-adds, plus total for round half up
	assign part_x   = NUM_W'(part);
	assign num_init = (part_x << 7) + (part_x << 6) + (part_x << 3) + NUM_W'(total);
	// quotient stays below 128, so the first trial is 2*total << 6
	assign den_init = NUM_W'(total) << PCT_W;
	assign ge       = rem_q >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(PCT_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num_init;
			den_q  <= den_init;
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - den_q;
			end
			den_q  <= den_q >> 1;
			quot_q <= {quot_q[PCT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

>>> sv/sensor_ring_direction_percent_unit.sv
// ----------------------------------------------------------------------------
// sensor_ring_direction_percent_unit
// Sums one scan of the 31-channel ring into four direction groups and reports
// each group's rounded share of the scan total when the last sample arrives.
// ----------------------------------------------------------------------------
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+----------------------------
//  input    | item_valid    | item_stall    | item   (chan, sample, last)
//  output   | result_valid  | result_stall  | result (four pct, zero_total)
//
//  samples without last are taken back to back; a last sample is taken, then the total
//  is registered, each group runs on the shared divider (load, quotient bits, collect)
//  and the result is handed over; with a zero total the divider is skipped
//  item_stall is high from the last sample until the result is registered
//  a held result stalls the next scan only at its final hand-over
//  reset clears the group sums and the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_ring_direction_percent_unit
	import srdp_pkg::*;
#(
	parameter int SUM_BITS = SUM_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam int TOT_W = SUM_BITS + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOTAL,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                              state_q;
	logic [GRP_IDX_W-1:0]                grp_q;
	logic [TOT_W-1:0]                    total_q;
	logic                                zero_q;
	logic [PCT_W-1:0]                    pct_q [NUM_GROUPS];
	result_t                             result_q;
	logic                                result_valid_q;
	logic [NUM_GROUPS-1:0][SUM_BITS-1:0] sums;
	logic                                accept;
	logic                                out_free;
	logic                                clear;
	logic                                div_start;
	logic                                div_done;
	logic [PCT_W-1:0]                    div_quot;
	logic [TOT_W-1:0]                    total_sum;

	assign item_stall = state_q != ST_IDLE;
	assign accept     = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;
	assign clear      = state_q == ST_DONE && out_free;
	assign div_start  = state_q == ST_LOAD;
	assign total_sum  = TOT_W'(sums[0]) + TOT_W'(sums[1]) + TOT_W'(sums[2])
		+ TOT_W'(sums[3]);

	srdp_accum #(
		.SUM_BITS (SUM_BITS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.add_en (accept),
		.chan   (item.chan),
		.sample (item.sample),
		.clear  (clear),
		.sums   (sums)
	);

	srdp_div #(
		.SUM_BITS (SUM_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.part   (sums[grp_q]),
		.total  (total_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			grp_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.last) begin
						state_q <= ST_TOTAL;
					end
				end
				ST_TOTAL: begin
					grp_q   <= '0;
					state_q <= (total_sum == '0) ? ST_DONE : ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						if (grp_q == GRP_IDX_W'(NUM_GROUPS-1)) begin
							state_q <= ST_DONE;
						end else begin
							grp_q   <= grp_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						result_q.left_pct   <= zero_q ? '0 : pct_q[GRP_IDX_W'(GRP_LEFT)];
						result_q.right_pct  <= zero_q ? '0 : pct_q[GRP_IDX_W'(GRP_RIGHT)];
						result_q.front_pct  <= zero_q ? '0 : pct_q[GRP_IDX_W'(GRP_FRONT)];
						result_q.back_pct   <= zero_q ? '0 : pct_q[GRP_IDX_W'(GRP_BACK)];
						result_q.zero_total <= zero_q;
						result_valid_q      <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TOTAL) begin
			total_q <= total_sum;
			zero_q  <= total_sum == '0;
		end
		if (state_q == ST_DIV && div_done) begin
			pct_q[grp_q] <= div_quot;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

>>> dv/tb_sensor_ring_direction_percent_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_ring_direction_percent_unit
// Streams scans of ring samples into the unit and checks every reported set
// of direction shares against a scan accumulator kept in the bench.
// ----------------------------------------------------------------------------

module tb_sensor_ring_direction_percent_unit
	import srdp_pkg::*;
();

	localparam int SUM_W       = SUM_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_CHAN_ITEMS = 1300;
	localparam logic [SUM_W-1:0] SUM_SAT = '1;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	item_t   item         = '0;
	logic    result_stall = 1'b0;
	logic    item_stall;
	logic    result_valid;
	result_t result;

	item_t            scan_samples [$];
	result_t          expected_shares [$];
	logic [SUM_W-1:0] group_sum [NUM_GROUPS];
	result_t          want_share;
	logic             in_taken      = 1'b0;
	int               send_idle_pct = 20;
	int               recv_idle_pct = 69;
	int               mismatches    = 0;
	int               cycle_count   = 0;

	sensor_ring_direction_percent_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #4 clk = ~clk;

	// ring layout: back wraps around 0 and 30, front is the even run 10..20
	function automatic grp_t ring_group(input logic [CHAN_W-1:0] c);
		if (c == 5'd31)
			return GRP_NONE;
		if (c <= 5'd4 || c >= 5'd26)
			return GRP_BACK;
		if (c <= 5'd9 || c == 5'd11 || c == 5'd13)
			return GRP_LEFT;
		if (c[0] == 1'b0 && c <= 5'd20)
			return GRP_FRONT;
		return GRP_RIGHT;
	endfunction

	function automatic logic [PCT_W-1:0] share_pct(input longint unsigned part,
		input longint unsigned total);
		longint unsigned q;
		q = (2 * PCT_SCALE * part + total) / (2 * total);
		return q[PCT_W-1:0];
	endfunction

	function automatic void take_sample(input item_t it);
		grp_t            g;
		longint unsigned s;
		longint unsigned total;
		result_t         r;
		g = ring_group(it.chan);
		if (g != GRP_NONE) begin
			s = group_sum[g] + it.sample;
			group_sum[g] = (s > SUM_SAT) ? SUM_SAT : s[SUM_W-1:0];
		end
		if (it.last) begin
			total = 0;
			for (int k = 0; k < NUM_GROUPS; k++)
				total += group_sum[k];
			r = '0;
			if (total == 0) begin
				r.zero_total = 1'b1;
			end else begin
				r.left_pct  = share_pct(group_sum[GRP_LEFT], total);
				r.right_pct = share_pct(group_sum[GRP_RIGHT], total);
				r.front_pct = share_pct(group_sum[GRP_FRONT], total);
				r.back_pct  = share_pct(group_sum[GRP_BACK], total);
			end
			expected_shares.push_back(r);
			for (int k = 0; k < NUM_GROUPS; k++)
				group_sum[k] = '0;
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void push_sample(input logic [CHAN_W-1:0] c,
		input logic [SAMPLE_W-1:0] s, input logic l);
		item_t it;
		it.chan   = c;
		it.sample = s;
		it.last   = l;
		scan_samples.push_back(it);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r <= 4)
			return SAMPLE_W'($urandom_range(15));
		return SAMPLE_W'($urandom_range(1023));
	endfunction

	function automatic logic [CHAN_W-1:0] pick_chan_in(input grp_t g);
		logic [CHAN_W-1:0] c;
		c = CHAN_W'($urandom_range(30));
		while (ring_group(c) != g)
			c = CHAN_W'($urandom_range(30));
		return c;
	endfunction

	initial begin
		for (int k = 0; k < NUM_GROUPS; k++)
			group_sum[k] = '0;
	end

	// driver: a new transaction only once the previous one has been taken
	always @(negedge clk) begin
		if (arst_n && (!item_valid || in_taken)) begin
			if (scan_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item       <= scan_samples.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
		result_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	// monitor for both channels
	always @(posedge clk) begin
		in_taken <= arst_n && item_valid && !item_stall;
		if (arst_n && item_valid && !item_stall)
			take_sample(item);
		if (arst_n && result_valid && !result_stall) begin
			if (expected_shares.size() == 0) begin
				$error("result transaction with no scan pending");
				mismatches++;
			end else begin
				want_share = expected_shares.pop_front();
				check_field("left_pct", 8'(want_share.left_pct), 8'(result.left_pct));
				check_field("right_pct", 8'(want_share.right_pct), 8'(result.right_pct));
				check_field("front_pct", 8'(want_share.front_pct), 8'(result.front_pct));
				check_field("back_pct", 8'(want_share.back_pct), 8'(result.back_pct));
				check_field("zero_total", 8'(want_share.zero_total),
					8'(result.zero_total));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int                counted;
		int                kind;
		int                len;
		int                total_items;
		bit                sat_done;
		logic [CHAN_W-1:0] c;
		grp_t              g;

		counted  = 0;
		sat_done = 1'b0;

		// last on an unmapped channel with nothing summed
		push_sample(5'd31, 10'd1023, 1'b1);
		// all-zero scan
		push_sample(5'd0, 10'd0, 1'b0);
		push_sample(5'd30, 10'd0, 1'b1);
		// full scale in every group
		push_sample(5'd13, 10'd1023, 1'b0);
		push_sample(5'd25, 10'd1023, 1'b0);
		push_sample(5'd20, 10'd1023, 1'b0);
		push_sample(5'd26, 10'd1023, 1'b1);
		// 12.5 / 87.5 split, rounds half up
		push_sample(5'd5, 10'd1, 1'b0);
		push_sample(5'd0, 10'd7, 1'b1);
		// single sample takes the whole scan
		push_sample(5'd10, 10'd1, 1'b1);
		// unmapped channel inside a scan is dropped
		push_sample(5'd31, 10'd1023, 1'b0);
		push_sample(5'd15, 10'd512, 1'b1);
		// thirds
		push_sample(5'd11, 10'd1, 1'b0);
		push_sample(5'd17, 10'd1, 1'b0);
		push_sample(5'd12, 10'd1, 1'b1);
		// tiny share rounds down to zero
		push_sample(5'd7, 10'd1, 1'b0);
		push_sample(5'd3, 10'd1023, 1'b0);
		push_sample(5'd28, 10'd1023, 1'b1);

		while (counted < RANDOM_CHAN_ITEMS) begin
			if (!sat_done && counted >= RANDOM_CHAN_ITEMS / 8) begin
				// drive one group past its sum ceiling
				g = grp_t'($urandom_range(3));
				repeat (1030)
					push_sample(pick_chan_in(g), 10'd1023, 1'b0);
				push_sample(CHAN_W'($urandom_range(30)), pick_sample(), 1'b1);
				counted += 1031;
				sat_done = 1'b1;
			end
			kind = $urandom_range(99);
			if (kind < 50) begin
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					c = ($urandom_range(19) == 0) ? 5'd31 : 5'($urandom_range(30));
					push_sample(c, pick_sample(), i == len - 1);
					if (c != 5'd31)
						counted++;
				end
			end else if (kind < 70) begin
				for (int i = 0; i <= 30; i++)
					push_sample(CHAN_W'(i), pick_sample(), i == 30);
				counted += 31;
			end else if (kind < 80) begin
				len = $urandom_range(1, 5);
				for (int i = 0; i < len; i++) begin
					c = CHAN_W'($urandom_range(31));
					push_sample(c, 10'd0, i == len - 1);
					if (c != 5'd31)
						counted++;
				end
			end else if (kind < 90) begin
				g = grp_t'($urandom_range(3));
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					push_sample(pick_chan_in(g), pick_sample(), i == len - 1);
				counted += len;
			end else begin
				push_sample(5'd31, SAMPLE_W'($urandom_range(1023)), 1'($urandom_range(1)));
			end
		end
		push_sample(CHAN_W'($urandom_range(31)), pick_sample(), 1'b1);
		total_items = scan_samples.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (scan_samples.size() > total_items * 2 / 3)
			@(posedge clk);
		send_idle_pct = 69;
		recv_idle_pct = 20;
		while (scan_samples.size() > total_items / 3)
			@(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (scan_samples.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_shares.size() != 0)
			@(negedge clk);
		repeat (50) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sensor_ring_direction_percent_unit.f
sv/srdp_pkg.sv
sv/srdp_accum.sv
sv/srdp_div.sv
sv/sensor_ring_direction_percent_unit.sv
dv/tb_sensor_ring_direction_percent_unit.sv
